[src/ncs_pkg.sv]
// ncs_pkg: shared constants, codes and control structs for the nearest center search block
// no dependencies

package ncs_pkg;

    localparam int MAX_CENTERS_DEF = 16;
    localparam int MAX_DIM_DEF     = 16;

    localparam int CFG_W     = 5;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 16;
    localparam int DIST_W    = 36;
    localparam int SQ_W      = 32;
    localparam int REG_IDX_W = 2;

    localparam logic CMD_CENTER = 1'b0;
    localparam logic CMD_POINT  = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_NUM_CENTERS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIMS        = 2'd1;

    typedef struct packed {
        logic wr_center;
        logic load_item;
        logic clear_acc;
        logic issue;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
    } t_dp_status;

endpackage

[src/ncs_if.sv]
// ncs_if: valid/ready channel interfaces for items, results and register writes
// depends on ncs_pkg

interface ncs_item_if;
    logic                            valid;
    logic                            ready;
    logic                            cmd;
    logic [ncs_pkg::IDX_W-1:0]       center_index;
    logic [ncs_pkg::IDX_W-1:0]       dim_index;
    logic signed [ncs_pkg::VAL_W-1:0] value;

    modport source (output valid, output cmd, output center_index, output dim_index,
                    output value, input ready);
    modport sink   (input valid, input cmd, input center_index, input dim_index,
                    input value, output ready);
endinterface

interface ncs_result_if;
    logic                       valid;
    logic                       ready;
    logic [ncs_pkg::IDX_W-1:0]  nearest_index;
    logic [ncs_pkg::DIST_W-1:0] nearest_distance;

    modport source (output valid, output nearest_index, output nearest_distance,
                    input ready);
    modport sink   (input valid, input nearest_index, input nearest_distance,
                    output ready);
endinterface

interface ncs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ncs_pkg::REG_IDX_W-1:0] index;
    logic [ncs_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/nearest_center_search.sv]
// nearest_center_search: top level joining the controller and the datapath
// depends on ncs_pkg, ncs_if, ncs_ctrl, ncs_dp
//
// channel   role    fields                                     handshake
// i_item    sink    cmd, center_index, dim_index, value        valid/ready
// o_result  source  nearest_index, nearest_distance            valid/ready
// i_cfg     sink    index, data (0 num_centers, 1 dims)        valid/ready, always ready
//
// a center write is stored from the idle state; a point coordinate visits the centers
// one per cycle through the shared multiplier, then a three-stage drain
// the last coordinate of a point waits in an emit state to load the result register
// new transactions wait while a coordinate is in flight; a result held by a stalled
// sink blocks only the next point end. reset clears control and accumulator valid bits

module nearest_center_search #(
    parameter int MAX_CENTERS = ncs_pkg::MAX_CENTERS_DEF,
    parameter int MAX_DIM     = ncs_pkg::MAX_DIM_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ncs_item_if.sink      i_item,
    ncs_result_if.source  o_result,
    ncs_cfg_if.sink       i_cfg
);

    localparam int CIW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

    ncs_pkg::t_dp_cmd    w_cmd;
    ncs_pkg::t_dp_status w_status;
    logic [CIW-1:0]      w_idx;

    ncs_ctrl #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_DIM     (MAX_DIM)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_item.valid),
        .i_in_cmd       (i_item.cmd),
        .i_in_dim_index (i_item.dim_index),
        .o_in_ready     (i_item.ready),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_cfg_ready    (i_cfg.ready),
        .i_status       (w_status),
        .o_cmd          (w_cmd),
        .o_idx          (w_idx)
    );

    ncs_dp #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_DIM     (MAX_DIM)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_idx              (w_idx),
        .i_center_index     (i_item.center_index),
        .i_dim_index        (i_item.dim_index),
        .i_value            (i_item.value),
        .o_status           (w_status),
        .o_nearest_index    (o_result.nearest_index),
        .o_nearest_distance (o_result.nearest_distance)
    );

endmodule

[src/ncs_ctrl.sv]
// ncs_ctrl: controller state machine, configuration registers and center walk counter
// depends on ncs_pkg

module ncs_ctrl #(
    parameter int MAX_CENTERS = ncs_pkg::MAX_CENTERS_DEF,
    parameter int MAX_DIM     = ncs_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_cmd,
    input  logic [ncs_pkg::IDX_W-1:0]       i_in_dim_index,
    output logic                            o_in_ready,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    input  logic                            i_cfg_valid,
    input  logic [ncs_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  logic [ncs_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                            o_cfg_ready,
    input  ncs_pkg::t_dp_status             i_status,
    output ncs_pkg::t_dp_cmd                o_cmd,
    output logic [((MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1)-1:0] o_idx
);

    localparam int CIW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CMPW = (CIW > ncs_pkg::CFG_W) ? CIW : ncs_pkg::CFG_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [CIW-1:0]             r_cnt, n_cnt;
    logic [ncs_pkg::CFG_W-1:0]  r_nc_last, n_nc_last;
    logic                       r_last, n_last;
    logic                       r_out_valid, n_out_valid;
    logic [ncs_pkg::CFG_W-1:0]  r_num_centers;
    logic [ncs_pkg::CFG_W-1:0]  r_dims;

    logic [ncs_pkg::CFG_W-1:0]  w_nc_eff;
    logic [ncs_pkg::CFG_W-1:0]  w_nd_eff;
    logic                       w_accept;
    logic                       w_cfg_accept;
    logic                       w_dim_ok;
    logic                       w_dim_last;
    logic                       w_out_free;

    // saturate registers into their legal ranges
    assign w_nc_eff = (r_num_centers == '0) ? ncs_pkg::CFG_W'(1) :
                      (9'(r_num_centers) > 9'(MAX_CENTERS)) ? ncs_pkg::CFG_W'(MAX_CENTERS) :
                      r_num_centers;
    assign w_nd_eff = (r_dims == '0) ? ncs_pkg::CFG_W'(1) :
                      (7'(r_dims) > 7'(MAX_DIM)) ? ncs_pkg::CFG_W'(MAX_DIM) :
                      r_dims;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_idx        = r_cnt;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_cfg_accept = i_cfg_valid && o_cfg_ready;
    assign w_dim_ok     = ncs_pkg::CFG_W'(i_in_dim_index) < w_nd_eff;
    assign w_dim_last   = ncs_pkg::CFG_W'(i_in_dim_index) == (w_nd_eff - ncs_pkg::CFG_W'(1));
    assign w_out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_nc_last   = r_nc_last;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_cmd == ncs_pkg::CMD_CENTER) begin
                        o_cmd.wr_center = 1'b1;
                    end else if (w_dim_ok) begin
                        o_cmd.load_item = 1'b1;
                        o_cmd.clear_acc = (i_in_dim_index == '0);
                        n_last          = w_dim_last;
                        n_nc_last       = w_nc_eff - ncs_pkg::CFG_W'(1);
                        n_cnt           = '0;
                        n_state         = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_cnt       = r_cnt + CIW'(1);
                if (CMPW'(r_cnt) == CMPW'(r_nc_last)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!i_status.pipe_busy) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.clear_acc = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_nc_last     <= '0;
            r_last        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_num_centers <= ncs_pkg::CFG_W'(1);
            r_dims        <= ncs_pkg::CFG_W'(1);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_nc_last   <= n_nc_last;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (w_cfg_accept) begin
                unique case (i_cfg_index)
                    ncs_pkg::REG_NUM_CENTERS: r_num_centers <= i_cfg_data;
                    ncs_pkg::REG_DIMS:        r_dims        <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

[src/ncs_dp.sv]
// ncs_dp: center store, distance accumulators, squared difference pipeline and minimum tracking
// depends on ncs_pkg

module ncs_dp #(
    parameter int MAX_CENTERS = ncs_pkg::MAX_CENTERS_DEF,
    parameter int MAX_DIM     = ncs_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ncs_pkg::t_dp_cmd                  i_cmd,
    input  logic [((MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1)-1:0] i_idx,
    input  logic [ncs_pkg::IDX_W-1:0]         i_center_index,
    input  logic [ncs_pkg::IDX_W-1:0]         i_dim_index,
    input  logic signed [ncs_pkg::VAL_W-1:0]  i_value,
    output ncs_pkg::t_dp_status               o_status,
    output logic [ncs_pkg::IDX_W-1:0]         o_nearest_index,
    output logic [ncs_pkg::DIST_W-1:0]        o_nearest_distance
);

    localparam int CIW   = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int DEPTH = MAX_CENTERS * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = ncs_pkg::VAL_W;
    localparam int DW    = ncs_pkg::DIST_W;

    logic signed [VW-1:0]   r_ctr_mem [DEPTH];
    logic [DW-1:0]          r_acc_mem [MAX_CENTERS];
    logic [MAX_CENTERS-1:0] r_acc_vld;

    logic signed [VW-1:0]   r_val;
    logic [ncs_pkg::IDX_W-1:0] r_di;

    logic                   r_v1, r_v2, r_v3;
    logic [CIW-1:0]         r_c1, r_c2, r_c3;
    logic                   r_first1, r_first2, r_first3;
    logic signed [VW-1:0]   r_ctr_rd;
    logic [DW-1:0]          r_acc_rd;
    logic                   r_vld_rd;
    logic [VW-1:0]          r_mag;
    logic [DW-1:0]          r_acc2, r_acc3;
    logic [ncs_pkg::SQ_W-1:0] r_sq;

    logic [CIW-1:0]         r_best_idx;
    logic [DW-1:0]          r_best_dist;
    logic [ncs_pkg::IDX_W-1:0] r_out_idx;
    logic [DW-1:0]          r_out_dist;

    logic                   w_wr_ok;
    logic [AW-1:0]          w_wr_addr;
    logic [AW-1:0]          w_rd_addr;
    logic signed [VW:0]     w_diff;
    logic [VW-1:0]          w_mag;
    logic [DW:0]            w_sum;
    logic [DW-1:0]          w_sat;

    assign w_wr_ok   = (9'(i_center_index) < 9'(MAX_CENTERS)) && (7'(i_dim_index) < 7'(MAX_DIM));
    assign w_wr_addr = AW'(i_center_index) * AW'(MAX_DIM) + AW'(i_dim_index);
    assign w_rd_addr = AW'(i_idx) * AW'(MAX_DIM) + AW'(r_di);

    assign w_diff = {r_val[VW-1], r_val} - {r_ctr_rd[VW-1], r_ctr_rd};
    assign w_mag  = w_diff[VW] ? VW'(-w_diff) : w_diff[VW-1:0];
    assign w_sum  = (DW+1)'(r_acc3) + (DW+1)'(r_sq);
    assign w_sat  = w_sum[DW] ? '1 : w_sum[DW-1:0];

    assign o_status.pipe_busy = r_v1 || r_v2 || r_v3;
    assign o_nearest_index    = r_out_idx;
    assign o_nearest_distance = r_out_dist;

    // center store and accumulator memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_center && w_wr_ok) begin
            r_ctr_mem[w_wr_addr] <= i_value;
        end
        if (i_cmd.issue) begin
            r_ctr_rd <= r_ctr_mem[w_rd_addr];
            r_acc_rd <= r_acc_mem[i_idx];
        end
        if (r_v3) begin
            r_acc_mem[r_c3] <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.clear_acc) begin
                r_acc_vld <= '0;
            end else if (r_v3) begin
                r_acc_vld[r_c3] <= 1'b1;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_val <= i_value;
            r_di  <= i_dim_index;
        end
        r_c1     <= i_idx;
        r_first1 <= (i_idx == '0);
        r_vld_rd <= r_acc_vld[i_idx];

        r_c2     <= r_c1;
        r_first2 <= r_first1;
        r_mag    <= w_mag;
        r_acc2   <= r_vld_rd ? r_acc_rd : '0;

        r_c3     <= r_c2;
        r_first3 <= r_first2;
        r_sq     <= r_mag * r_mag;
        r_acc3   <= r_acc2;

        // strict compare keeps the lower index on ties
        if (r_v3 && (r_first3 || (w_sat < r_best_dist))) begin
            r_best_idx  <= r_c3;
            r_best_dist <= w_sat;
        end
        if (i_cmd.load_out) begin
            r_out_idx  <= ncs_pkg::IDX_W'(r_best_idx);
            r_out_dist <= r_best_dist;
        end
    end

endmodule
